[rtl/ppcfc_pkg.sv]
`default_nettype none

package ppcfc_pkg;

    localparam int unsigned PixelWidth  = 8;
    localparam int unsigned FormatWidth = 3;

    localparam logic [FormatWidth-1:0] FMT_GREY       = 3'd0;
    localparam logic [FormatWidth-1:0] FMT_RGB        = 3'd1;
    localparam logic [FormatWidth-1:0] FMT_RGBA       = 3'd2;
    localparam logic [FormatWidth-1:0] FMT_YUV_PACKED = 3'd3;
    localparam logic [FormatWidth-1:0] FMT_YUV_PLANAR = 3'd4;

    localparam logic [FormatWidth-1:0] SOURCE_RESET = FMT_RGB;
    localparam logic [FormatWidth-1:0] DEST_RESET   = FMT_YUV_PACKED;

    localparam logic REG_SOURCE_FORMAT = 1'b0;
    localparam logic REG_DEST_FORMAT   = 1'b1;

    // reciprocals for truncating division by 1000, 3, 200 and 100
    localparam logic [18:0] RECIP_1000 = 19'd268436;
    localparam int unsigned SHIFT_1000 = 28;
    localparam logic [9:0]  RECIP_3    = 10'd683;
    localparam int unsigned SHIFT_3    = 11;
    localparam logic [16:0] RECIP_200  = 17'd83887;
    localparam int unsigned SHIFT_200  = 24;
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int unsigned SHIFT_100  = 19;

    localparam logic [7:0] CHROMA_MID = 8'd128;

    typedef enum logic [1:0] {
        KIND_GREY,
        KIND_RGB,
        KIND_YUV,
        KIND_BAD
    } kind_t;

    typedef enum logic [3:0] {
        MODE_ZERO,
        MODE_PASS_GREY,
        MODE_PASS_RGB,
        MODE_PASS_YUV,
        MODE_GREY_RGB,
        MODE_GREY_YUV,
        MODE_RGB_GREY,
        MODE_RGB_YUV,
        MODE_YUV_GREY,
        MODE_YUV_RGB
    } mode_t;

    function automatic kind_t kind_of(input logic [FormatWidth-1:0] fmt);
        kind_t k;
        case (fmt)
            FMT_GREY:                       k = KIND_GREY;
            FMT_RGB, FMT_RGBA:              k = KIND_RGB;
            FMT_YUV_PACKED, FMT_YUV_PLANAR: k = KIND_YUV;
            default:                        k = KIND_BAD;
        endcase
        return k;
    endfunction

    function automatic mode_t mode_of(input logic [FormatWidth-1:0] src,
                                      input logic [FormatWidth-1:0] dst);
        kind_t sk;
        kind_t dk;
        mode_t m;
        sk = kind_of(src);
        dk = kind_of(dst);
        m  = MODE_ZERO;
        if (sk == KIND_BAD || dk == KIND_BAD)
        begin
            m = MODE_ZERO;
        end
        else if (sk == dk)
        begin
            case (sk)
                KIND_GREY: m = MODE_PASS_GREY;
                KIND_RGB:  m = MODE_PASS_RGB;
                default:   m = MODE_PASS_YUV;
            endcase
        end
        else
        begin
            case (sk)
                KIND_GREY: m = (dk == KIND_RGB) ? MODE_GREY_RGB : MODE_GREY_YUV;
                KIND_RGB:  m = (dk == KIND_GREY) ? MODE_RGB_GREY : MODE_RGB_YUV;
                default:   m = (dk == KIND_GREY) ? MODE_YUV_GREY : MODE_YUV_RGB;
            endcase
        end
        return m;
    endfunction

    // arithmetic shift right by 8 and clamp to 0..255; negative gives 0
    function automatic logic [7:0] shift_clamp(input logic signed [18:0] x);
        logic [7:0] r;
        if (x[18])
        begin
            r = 8'd0;
        end
        else if (x[17:16] != 2'd0)
        begin
            r = 8'd255;
        end
        else
        begin
            r = x[15:8];
        end
        return r;
    endfunction

    // 128 - q, floored at zero
    function automatic logic [7:0] mid_minus(input logic [7:0] q);
        logic [7:0] r;
        if (q > CHROMA_MID)
        begin
            r = 8'd0;
        end
        else
        begin
            r = CHROMA_MID - q;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/pixel_pair_colour_format_converter_core.sv]
`default_nettype none

// Pixel pair colour format converter: takes one horizontal pixel pair per
// request on s_axis and returns it in the destination format on m_axis.
// Formats: 0 grey, 1 RGB, 2 RGBA, 3 packed YUV422, 4 planar YUV422, set by
// cfg register 0 (source) and 1 (destination); other codes give all-zero
// results. YUV to RGB uses BT.601 integer weights, RGB to YUV truncating
// divisions by 1000 and 200, all clamped to 0..255; alpha is always 0.
// The datapath is a four-stage pipeline (input capture, weighted sums,
// reciprocal multiplies, clamp and select): one pair per clock unless m_axis
// stalls, which holds each full stage in place while empty stages fill.
// Write the format registers only while the pipeline is empty.
module pixel_pair_colour_format_converter_core
    import ppcfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [2:0]  cfg_data,

    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // first_c0, first_c1, first_c2, second_c0, second_c1, second_c2
    input  wire logic [47:0] s_axis_tdata,

    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_first_c0, out_first_c1, out_first_c2, out_first_alpha,
    // out_second_c0, out_second_c1, out_second_c2, out_second_alpha
    output      logic [63:0] m_axis_tdata
);

    logic [FormatWidth-1:0] source_format_reg;
    logic [FormatWidth-1:0] dest_format_reg;

    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: captured request
    mode_t      mode1_reg;
    logic [7:0] a0_reg, a1_reg, a2_reg, b0_reg, b1_reg, b2_reg;

    // stage 2: weighted sums
    mode_t             mode2_reg;
    logic [7:0]        a0_2_reg, a1_2_reg, a2_2_reg, b0_2_reg, b1_2_reg, b2_2_reg;
    logic [9:0]        gsum0_reg, gsum1_reg;
    logic [17:0]       lsum0_reg, lsum1_reg;
    logic [15:0]       csum_reg;
    logic [14:0]       tabs_reg;
    logic              tneg_reg;
    logic [14:0]       gu0_reg, gu1_reg;
    logic signed [18:0] yr0_reg, yg0_reg, yb0_reg, yr1_reg, yg1_reg, yb1_reg;

    // stage 3: quotients and clamped colors
    mode_t      mode3_reg;
    logic [7:0] a0_3_reg, a1_3_reg, a2_3_reg, b0_3_reg, b1_3_reg, b2_3_reg;
    logic [7:0] grey0_reg, grey1_reg, luma0_reg, luma1_reg;
    logic [7:0] sq_reg, tq_reg, gq0_reg, gq1_reg;
    logic       tneg3_reg;
    logic [7:0] r0_reg, g0_reg, bl0_reg, r1_reg, g1_reg, bl1_reg;

    // stage 4: output
    mode_t      mode4_reg;
    logic [63:0] out_reg;
    logic [63:0] out_next;

    logic signed [9:0]  c0_s, c1_s, d_s, e_s;
    logic signed [15:0] t_s;
    logic [36:0] lprod0, lprod1;
    logic [19:0] gprod0, gprod1;
    logic [32:0] sprod;
    logic [31:0] tprod;
    logic [27:0] uprod0, uprod1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg <= SOURCE_RESET;
            dest_format_reg   <= DEST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SOURCE_FORMAT: source_format_reg <= cfg_data;
                REG_DEST_FORMAT:   dest_format_reg   <= cfg_data;
                default:           source_format_reg <= source_format_reg;
            endcase
        end
    end

    // advance a stage when it is empty or its successor advances
    assign en4           = !v4_reg || m_axis_tready;
    assign en3           = !v3_reg || en4;
    assign en2           = !v2_reg || en3;
    assign en1           = !v1_reg || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mode1_reg <= mode_of(source_format_reg, dest_format_reg);
            a0_reg    <= s_axis_tdata[7:0];
            a1_reg    <= s_axis_tdata[15:8];
            a2_reg    <= s_axis_tdata[23:16];
            b0_reg    <= s_axis_tdata[31:24];
            b1_reg    <= s_axis_tdata[39:32];
            b2_reg    <= s_axis_tdata[47:40];
        end
    end

    assign c0_s = $signed({2'b00, a0_reg}) - 10'sd16;
    assign c1_s = $signed({2'b00, b0_reg}) - 10'sd16;
    assign d_s  = $signed({2'b00, a1_reg}) - 10'sd128;
    assign e_s  = $signed({2'b00, a2_reg}) - 10'sd128;
    assign t_s  = 16'sd36 * $signed({8'd0, a0_reg} + {8'd0, b0_reg})
                - 16'sd29 * $signed({8'd0, a1_reg} + {8'd0, b1_reg})
                - 16'sd7  * $signed({8'd0, a2_reg} + {8'd0, b2_reg});

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            mode2_reg <= mode1_reg;
            a0_2_reg  <= a0_reg;
            a1_2_reg  <= a1_reg;
            a2_2_reg  <= a2_reg;
            b0_2_reg  <= b0_reg;
            b1_2_reg  <= b1_reg;
            b2_2_reg  <= b2_reg;
            gsum0_reg <= {2'b00, a0_reg} + {2'b00, a1_reg} + {2'b00, a2_reg};
            gsum1_reg <= {2'b00, b0_reg} + {2'b00, b1_reg} + {2'b00, b2_reg};
            lsum0_reg <= 18'd299 * {10'd0, a0_reg} + 18'd587 * {10'd0, a1_reg}
                       + 18'd114 * {10'd0, a2_reg};
            lsum1_reg <= 18'd299 * {10'd0, b0_reg} + 18'd587 * {10'd0, b1_reg}
                       + 18'd114 * {10'd0, b2_reg};
            csum_reg  <= 16'd14 * ({8'd0, a0_reg} + {8'd0, b0_reg})
                       + 16'd29 * ({8'd0, a1_reg} + {8'd0, b1_reg})
                       + 16'd43 * ({8'd0, a2_reg} + {8'd0, b2_reg});
            tneg_reg  <= t_s[15];
            tabs_reg  <= t_s[15] ? 15'(-t_s) : t_s[14:0];
            gu0_reg   <= 15'd86 * {7'd0, a0_reg};
            gu1_reg   <= 15'd86 * {7'd0, b0_reg};
            yr0_reg   <= 19'sd298 * 19'(c0_s) + 19'sd409 * 19'(e_s) + 19'sd128;
            yg0_reg   <= 19'sd298 * 19'(c0_s) - 19'sd100 * 19'(d_s)
                       - 19'sd208 * 19'(e_s) + 19'sd128;
            yb0_reg   <= 19'sd298 * 19'(c0_s) + 19'sd516 * 19'(d_s) + 19'sd128;
            yr1_reg   <= 19'sd298 * 19'(c1_s) + 19'sd409 * 19'(e_s) + 19'sd128;
            yg1_reg   <= 19'sd298 * 19'(c1_s) - 19'sd100 * 19'(d_s)
                       - 19'sd208 * 19'(e_s) + 19'sd128;
            yb1_reg   <= 19'sd298 * 19'(c1_s) + 19'sd516 * 19'(d_s) + 19'sd128;
        end
    end

    assign lprod0 = {19'd0, lsum0_reg} * {18'd0, RECIP_1000};
    assign lprod1 = {19'd0, lsum1_reg} * {18'd0, RECIP_1000};
    assign gprod0 = {10'd0, gsum0_reg} * {10'd0, RECIP_3};
    assign gprod1 = {10'd0, gsum1_reg} * {10'd0, RECIP_3};
    assign sprod  = {17'd0, csum_reg} * {16'd0, RECIP_200};
    assign tprod  = {17'd0, tabs_reg} * {15'd0, RECIP_200};
    assign uprod0 = {13'd0, gu0_reg} * {15'd0, RECIP_100};
    assign uprod1 = {13'd0, gu1_reg} * {15'd0, RECIP_100};

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            mode3_reg <= mode2_reg;
            a0_3_reg  <= a0_2_reg;
            a1_3_reg  <= a1_2_reg;
            a2_3_reg  <= a2_2_reg;
            b0_3_reg  <= b0_2_reg;
            b1_3_reg  <= b1_2_reg;
            b2_3_reg  <= b2_2_reg;
            luma0_reg <= lprod0[SHIFT_1000 +: 8];
            luma1_reg <= lprod1[SHIFT_1000 +: 8];
            grey0_reg <= gprod0[SHIFT_3 +: 8];
            grey1_reg <= gprod1[SHIFT_3 +: 8];
            sq_reg    <= sprod[SHIFT_200 +: 8];
            tq_reg    <= tprod[SHIFT_200 +: 8];
            tneg3_reg <= tneg_reg;
            gq0_reg   <= uprod0[SHIFT_100 +: 8];
            gq1_reg   <= uprod1[SHIFT_100 +: 8];
            r0_reg    <= shift_clamp(yr0_reg);
            g0_reg    <= shift_clamp(yg0_reg);
            bl0_reg   <= shift_clamp(yb0_reg);
            r1_reg    <= shift_clamp(yr1_reg);
            g1_reg    <= shift_clamp(yg1_reg);
            bl1_reg   <= shift_clamp(yb1_reg);
        end
    end

    always_comb
    begin
        logic [8:0] usum;
        usum     = {1'b0, mid_minus(gq0_reg)} + {1'b0, mid_minus(gq1_reg)};
        out_next = '0;
        case (mode3_reg)
            MODE_PASS_GREY, MODE_YUV_GREY:
            begin
                out_next[7:0]   = a0_3_reg;
                out_next[39:32] = b0_3_reg;
            end
            MODE_PASS_YUV:
            begin
                out_next[7:0]   = a0_3_reg;
                out_next[15:8]  = a1_3_reg;
                out_next[23:16] = a2_3_reg;
                out_next[39:32] = b0_3_reg;
            end
            MODE_PASS_RGB:
            begin
                out_next[7:0]   = a0_3_reg;
                out_next[15:8]  = a1_3_reg;
                out_next[23:16] = a2_3_reg;
                out_next[39:32] = b0_3_reg;
                out_next[47:40] = b1_3_reg;
                out_next[55:48] = b2_3_reg;
            end
            MODE_GREY_RGB:
            begin
                out_next[7:0]   = a0_3_reg;
                out_next[15:8]  = a0_3_reg;
                out_next[23:16] = a0_3_reg;
                out_next[39:32] = b0_3_reg;
                out_next[47:40] = b0_3_reg;
                out_next[55:48] = b0_3_reg;
            end
            MODE_GREY_YUV:
            begin
                out_next[7:0]   = a0_3_reg;
                out_next[15:8]  = usum[8:1];
                out_next[23:16] = CHROMA_MID;
                out_next[39:32] = b0_3_reg;
            end
            MODE_RGB_GREY:
            begin
                out_next[7:0]   = grey0_reg;
                out_next[39:32] = grey1_reg;
            end
            MODE_RGB_YUV:
            begin
                out_next[7:0]   = luma0_reg;
                out_next[15:8]  = mid_minus(sq_reg);
                out_next[23:16] = tneg3_reg ? mid_minus(tq_reg) : CHROMA_MID + tq_reg;
                out_next[39:32] = luma1_reg;
            end
            MODE_YUV_RGB:
            begin
                out_next[7:0]   = r0_reg;
                out_next[15:8]  = g0_reg;
                out_next[23:16] = bl0_reg;
                out_next[39:32] = r1_reg;
                out_next[47:40] = g1_reg;
                out_next[55:48] = bl1_reg;
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            mode4_reg <= mode3_reg;
            out_reg   <= out_next;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = out_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:24] == 8'd0 && m_axis_tdata[63:56] == 8'd0))
        else $error("alpha byte not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && mode4_reg == MODE_ZERO) |-> (m_axis_tdata == 64'd0))
        else $error("unsupported format produced nonzero data");

    assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && (mode4_reg == MODE_PASS_GREY || mode4_reg == MODE_RGB_GREY
                    || mode4_reg == MODE_YUV_GREY))
        |-> (m_axis_tdata[23:8] == 16'd0 && m_axis_tdata[55:40] == 16'd0))
        else $error("grey result carries chroma");

    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !en4) |=> (v3_reg && $stable(luma0_reg) && $stable(r0_reg)))
        else $error("stage 3 lost data during stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en2) |=> (v1_reg && $stable(a0_reg) && $stable(mode1_reg)))
        else $error("stage 1 lost data during stall");
`endif

endmodule

`default_nettype wire

[test/pixel_pair_colour_format_converter_core_tb.sv]
`default_nettype none

module pixel_pair_colour_format_converter_core_tb;
    import ppcfc_pkg::*;

    localparam logic [2:0] FMT_UNUSED_A = 3'd5;
    localparam logic [2:0] FMT_UNUSED_B = 3'd6;
    localparam logic [2:0] FMT_UNUSED_C = 3'd7;

    localparam int DIRECTED_ROWS = 22;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic [2:0]  src;
        logic [2:0]  dst;
        logic [47:0] pair;
        logic        known;
        logic [63:0] result;
    } pair_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [2:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;

    logic [2:0]  src_shadow;
    logic [2:0]  dst_shadow;
    logic [63:0] pending_pairs [$];
    logic [63:0] want_pair;
    pair_row_t   rows [0:DIRECTED_ROWS-1];
    int          error_count;
    int          cycle_count;
    int          stall_mode;
    int          stall_left;
    int          sent_count;
    int          phase;
    int          left;
    int          burst;
    int          gap;

    pixel_pair_colour_format_converter_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic kind_t format_kind(input logic [2:0] fmt);
        kind_t k;
        case (fmt)
            FMT_GREY:                       k = KIND_GREY;
            FMT_RGB, FMT_RGBA:              k = KIND_RGB;
            FMT_YUV_PACKED, FMT_YUV_PLANAR: k = KIND_YUV;
            default:                        k = KIND_BAD;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] clip_byte(input int x);
        logic [7:0] r;
        if (x > 255)
        begin
            r = 8'd255;
        end
        else if (x < 0)
        begin
            r = 8'd0;
        end
        else
        begin
            r = x[7:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] scale_down(input int x);
        logic [7:0] r;
        if (x < 0)
        begin
            r = 8'd0;
        end
        else
        begin
            r = clip_byte(x >>> 8);
        end
        return r;
    endfunction

    function automatic logic [7:0] weighted_luma(input int r, input int g, input int b);
        return clip_byte((299 * r + 587 * g + 114 * b) / 1000);
    endfunction

    // {B, G, R} of one pixel
    function automatic logic [23:0] yuv_pixel(input int y, input int u, input int v);
        int c;
        int d;
        int e;
        c = y - 16;
        d = u - 128;
        e = v - 128;
        return {scale_down(298 * c + 516 * d + 128),
                scale_down(298 * c - 100 * d - 208 * e + 128),
                scale_down(298 * c + 409 * e + 128)};
    endfunction

    function automatic logic [63:0] convert_pair(input logic [2:0] src, input logic [2:0] dst,
                                                 input logic [47:0] pair);
        int          a0;
        int          a1;
        int          a2;
        int          b0;
        int          b1;
        int          b2;
        int          s;
        int          t;
        int          u0;
        int          u1;
        kind_t       sk;
        kind_t       dk;
        logic [7:0]  o [0:7];
        logic [23:0] px0;
        logic [23:0] px1;
        a0 = {24'd0, pair[7:0]};
        a1 = {24'd0, pair[15:8]};
        a2 = {24'd0, pair[23:16]};
        b0 = {24'd0, pair[31:24]};
        b1 = {24'd0, pair[39:32]};
        b2 = {24'd0, pair[47:40]};
        sk = format_kind(src);
        dk = format_kind(dst);
        for (int i = 0; i < 8; i++)
        begin
            o[i] = 8'd0;
        end
        if (sk == KIND_BAD || dk == KIND_BAD)
        begin
            o[0] = 8'd0;
        end
        else if (sk == dk)
        begin
            o[0] = a0[7:0];
            o[4] = b0[7:0];
            if (sk != KIND_GREY)
            begin
                o[1] = a1[7:0];
                o[2] = a2[7:0];
            end
            if (sk == KIND_RGB)
            begin
                o[5] = b1[7:0];
                o[6] = b2[7:0];
            end
        end
        else if (sk == KIND_GREY)
        begin
            if (dk == KIND_RGB)
            begin
                o[0] = a0[7:0];
                o[1] = a0[7:0];
                o[2] = a0[7:0];
                o[4] = b0[7:0];
                o[5] = b0[7:0];
                o[6] = b0[7:0];
            end
            else
            begin
                u0 = {24'd0, clip_byte(128 - (86 * a0) / 100)};
                u1 = {24'd0, clip_byte(128 - (86 * b0) / 100)};
                o[0] = weighted_luma(a0, a0, a0);
                o[4] = weighted_luma(b0, b0, b0);
                o[1] = clip_byte((u0 + u1) / 2);
                o[2] = clip_byte((2 * clip_byte(128)) / 2);
            end
        end
        else if (sk == KIND_RGB)
        begin
            if (dk == KIND_GREY)
            begin
                o[0] = clip_byte((a0 + a1 + a2) / 3);
                o[4] = clip_byte((b0 + b1 + b2) / 3);
            end
            else
            begin
                s = (14 * a0 + 29 * a1 + 43 * a2) + (14 * b0 + 29 * b1 + 43 * b2);
                t = (36 * a0 - 29 * a1 - 7 * a2) + (36 * b0 - 29 * b1 - 7 * b2);
                o[0] = weighted_luma(a0, a1, a2);
                o[4] = weighted_luma(b0, b1, b2);
                o[1] = clip_byte(128 - s / 200);
                o[2] = clip_byte(128 + t / 200);
            end
        end
        else
        begin
            if (dk == KIND_GREY)
            begin
                o[0] = a0[7:0];
                o[4] = b0[7:0];
            end
            else
            begin
                px0 = yuv_pixel(a0, a1, a2);
                px1 = yuv_pixel(b0, a1, a2);
                o[0] = px0[7:0];
                o[1] = px0[15:8];
                o[2] = px0[23:16];
                o[4] = px1[7:0];
                o[5] = px1[15:8];
                o[6] = px1[23:16];
            end
        end
        return {o[7], o[6], o[5], o[4], o[3], o[2], o[1], o[0]};
    endfunction

    function automatic logic [7:0] random_level();
        logic [7:0] r;
        if ($urandom_range(0, 3) == 0)
        begin
            r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        else
        begin
            r = 8'($urandom_range(0, 255));
        end
        return r;
    endfunction

    function automatic logic [2:0] random_format();
        logic [2:0] f;
        if ($urandom_range(0, 9) == 0)
        begin
            f = 3'($urandom_range(5, 7));
        end
        else
        begin
            f = 3'($urandom_range(0, 4));
        end
        return f;
    endfunction

    task automatic note_mismatch(input string what, input int field,
                                 input logic [7:0] got, input logic [7:0] want);
        $display("mismatch at cycle %0d: %s field %0d got %02h want %02h",
                 cycle_count, what, field, got, want);
        error_count++;
    endtask

    task automatic write_format(input logic idx, input logic [2:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (idx == REG_SOURCE_FORMAT)
        begin
            src_shadow = val;
        end
        else
        begin
            dst_shadow = val;
        end
    endtask

    // caller drops the request valid before this
    task automatic apply_formats(input logic [2:0] src, input logic [2:0] dst);
        while (pending_pairs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_format(REG_SOURCE_FORMAT, src);
        write_format(REG_DEST_FORMAT, dst);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pair(input logic [47:0] pair, input logic known,
                             input logic [63:0] result);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pair;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        if (known)
        begin
            pending_pairs.push_back(result);
        end
        else
        begin
            pending_pairs.push_back(convert_pair(src_shadow, dst_shadow, pair));
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL pixel_pair_colour_format_converter_core");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 200);
        end
        else
        begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (cycle_count % 4) != 0;
            default: m_axis_tready <= $urandom_range(0, 7) == 0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pairs.size() == 0)
            begin
                note_mismatch("unrequested result", -1, m_axis_tdata[7:0], 8'd0);
            end
            else
            begin
                want_pair = pending_pairs.pop_front();
                for (int f = 0; f < 8; f++)
                begin
                    if (m_axis_tdata[8*f +: 8] !== want_pair[8*f +: 8])
                    begin
                        note_mismatch("result", f, m_axis_tdata[8*f +: 8], want_pair[8*f +: 8]);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_SOURCE_FORMAT;
        cfg_data      = FMT_GREY;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 48'd0;
        m_axis_tready = 1'b0;
        src_shadow    = SOURCE_RESET;
        dst_shadow    = DEST_RESET;
        error_count   = 0;
        cycle_count   = 0;
        stall_mode    = 0;
        stall_left    = 0;
        sent_count    = 0;
        phase         = 0;

        rows[0]  = '{FMT_RGB, FMT_YUV_PACKED, 48'h000000000000, 1'b1, 64'h0000000000808000};
        rows[1]  = '{FMT_RGB, FMT_YUV_PACKED, 48'hFFFFFFFFFFFF, 1'b1, 64'h000000FF008000FF};
        rows[2]  = '{FMT_RGB, FMT_YUV_PACKED, 48'h0000FF0000FF, 1'b0, 64'd0};
        rows[3]  = '{FMT_RGB, FMT_YUV_PLANAR, 48'hFF0000FF0000, 1'b0, 64'd0};
        rows[4]  = '{FMT_RGB, FMT_YUV_PLANAR, 48'h00FF0000FF00, 1'b0, 64'd0};
        rows[5]  = '{FMT_RGBA, FMT_GREY, 48'hFFFFFFFFFFFF, 1'b1, 64'h000000FF000000FF};
        rows[6]  = '{FMT_RGBA, FMT_GREY, 48'h01FE7F80FF01, 1'b0, 64'd0};
        rows[7]  = '{FMT_RGB, FMT_RGBA, 48'hFFFFFFFFFFFF, 1'b1, 64'h00FFFFFF00FFFFFF};
        rows[8]  = '{FMT_RGB, FMT_RGB, 48'hAA55AA55AA55, 1'b0, 64'd0};
        rows[9]  = '{FMT_GREY, FMT_GREY, 48'hFFFFFFFFFFFF, 1'b1, 64'h000000FF000000FF};
        rows[10] = '{FMT_GREY, FMT_RGB, 48'h123456FF7800, 1'b0, 64'd0};
        rows[11] = '{FMT_GREY, FMT_RGBA, 48'hFFFF00000000, 1'b0, 64'd0};
        rows[12] = '{FMT_GREY, FMT_YUV_PACKED, 48'h0000FF0000FF, 1'b0, 64'd0};
        rows[13] = '{FMT_GREY, FMT_YUV_PLANAR, 48'hFFFFFF000000, 1'b0, 64'd0};
        rows[14] = '{FMT_YUV_PACKED, FMT_RGB, 48'h000000000000, 1'b0, 64'd0};
        rows[15] = '{FMT_YUV_PACKED, FMT_RGBA, 48'h0000EB8080EB, 1'b0, 64'd0};
        rows[16] = '{FMT_YUV_PLANAR, FMT_RGB, 48'hFFFFFFFFFFFF, 1'b0, 64'd0};
        rows[17] = '{FMT_YUV_PLANAR, FMT_GREY, 48'hFFFF10FF0010, 1'b0, 64'd0};
        rows[18] = '{FMT_YUV_PACKED, FMT_YUV_PLANAR, 48'hFFFFFFFFFFFF, 1'b1, 64'h000000FF00FFFFFF};
        rows[19] = '{FMT_UNUSED_A, FMT_RGB, 48'hFFFFFFFFFFFF, 1'b1, 64'd0};
        rows[20] = '{FMT_RGB, FMT_UNUSED_C, 48'hFFFFFFFFFFFF, 1'b1, 64'd0};
        rows[21] = '{FMT_UNUSED_C, FMT_UNUSED_B, 48'hFFFFFFFFFFFF, 1'b1, 64'd0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (rows[r].src != src_shadow || rows[r].dst != dst_shadow)
            begin
                s_axis_tvalid <= 1'b0;
                apply_formats(rows[r].src, rows[r].dst);
            end
            send_pair(rows[r].pair, rows[r].known, rows[r].result);
        end

        while (sent_count < RANDOM_ITEMS)
        begin
            s_axis_tvalid <= 1'b0;
            case (phase)
                0:       apply_formats(FMT_GREY, FMT_YUV_PLANAR);
                1:       apply_formats(FMT_YUV_PLANAR, FMT_GREY);
                2:       apply_formats(FMT_UNUSED_C, FMT_UNUSED_A);
                3:       apply_formats(FMT_RGBA, FMT_YUV_PLANAR);
                default: apply_formats(random_format(), random_format());
            endcase
            left = $urandom_range(20, 120);
            while (left > 0)
            begin
                burst = $urandom_range(1, 24);
                gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                for (int k = 0; k < burst && left > 0; k++)
                begin
                    send_pair({random_level(), random_level(), random_level(),
                               random_level(), random_level(), random_level()},
                              1'b0, 64'd0);
                    left--;
                    sent_count++;
                end
                if (gap > 0 && left > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        while (pending_pairs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES * 4) @(posedge clk);
        if (pending_pairs.size() != 0)
        begin
            note_mismatch("missing result", -1, 8'd0, 8'd0);
        end
        if (error_count == 0)
        begin
            $display("PASS pixel_pair_colour_format_converter_core");
        end
        else
        begin
            $display("FAIL pixel_pair_colour_format_converter_core");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/ppcfc_pkg.sv
rtl/pixel_pair_colour_format_converter_core.sv
test/pixel_pair_colour_format_converter_core_tb.sv
